// ----- sv/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, codes and controller/datapath types for the banker's
// algorithm safety checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Default sizing of the stores
  localparam int unsigned DEF_PROCESSES   = 8;
  localparam int unsigned DEF_RESOURCES   = 4;
  localparam int unsigned DEF_VALUE_WIDTH = 16;

  // Fixed payload widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned PIDX_IN_W  = 3;
  localparam int unsigned RIDX_IN_W  = 2;
  localparam int unsigned VAL_IN_W   = 16;
  localparam int unsigned GP_W       = 3;

  // Configuration port
  localparam int unsigned PC_W       = 4;
  localparam int unsigned RC_W       = 3;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 1'd1;

  localparam logic [PC_W-1:0] PCOUNT_RST = 4'd8;
  localparam logic [RC_W-1:0] RCOUNT_RST = 3'd4;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_PROC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_AVAIL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN        = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic take;        // input ready
    logic init;        // clear flags, copy available into work
    logic new_pass;    // restart scan at process 0
    logic next_p;      // advance process pointer
    logic start_proc;  // reset resource pointer and fit flag
    logic rd;          // read need/held entry of current process/resource
    logic eval;        // compare need and build tentative work
    logic next_r;      // advance resource pointer
    logic grant;       // commit tentative work, mark process finished
    logic emit_grant;  // load a grant beat into the output register
    logic emit_fail;   // load the unsafe beat into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic run_req;     // valid input beat asks for a run
    logic p_end;       // process pointer past the last process
    logic p_done;      // current process already finished
    logic r_last;      // current resource is the last one
    logic fits;        // all needs of the current process fit
    logic progress;    // this pass granted something
    logic all_granted; // every process granted
    logic out_free;    // output register can take a beat
  } sts_t;

endpackage

// ----- sv/bsc_req_if.sv -----
// ----------------------------------------------------------------------------
// bsc_req_if
// Input channel: load and run requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_req_if import bsc_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [PIDX_IN_W-1:0] process_index;
  logic [RIDX_IN_W-1:0] resource_index;
  logic [VAL_IN_W-1:0]  max_value;
  logic [VAL_IN_W-1:0]  held_value;
  logic [VAL_IN_W-1:0]  avail_value;

  modport source (
    output valid, func, process_index, resource_index, max_value, held_value, avail_value,
    input  ready
  );

  modport sink (
    input  valid, func, process_index, resource_index, max_value, held_value, avail_value,
    output ready
  );

endinterface

// ----- sv/bsc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bsc_rsp_if
// Output channel: safe-sequence beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_rsp_if import bsc_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [GP_W-1:0] granted_process;
  logic            safe;
  logic            last;

  modport source (
    output valid, granted_process, safe, last,
    input  ready
  );

  modport sink (
    input  valid, granted_process, safe, last,
    output ready
  );

endinterface

// ----- sv/bsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer of the safety check: walks processes pass after pass and
// resources within a process, and hands beats to the output register.
// ----------------------------------------------------------------------------
module bsc_ctrl import bsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EV   = 3'd4;
  localparam logic [2:0] S_DEC  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;
  localparam logic [2:0] S_FAIL = 3'd7;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (sts_i.run_req) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_SEL;
      end
      S_SEL: begin
        priority if (sts_i.p_end) begin
          if (sts_i.progress) begin
            cmd_o.new_pass = 1'b1;
          end else begin
            state_d = S_FAIL;
          end
        end else if (sts_i.p_done) begin
          cmd_o.next_p = 1'b1;
        end else begin
          cmd_o.start_proc = 1'b1;
          state_d          = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EV;
      end
      S_EV: begin
        cmd_o.eval = 1'b1;
        if (sts_i.r_last) begin
          state_d = S_DEC;
        end else begin
          cmd_o.next_r = 1'b1;
          state_d      = S_RD;
        end
      end
      S_DEC: begin
        if (sts_i.fits) begin
          cmd_o.grant = 1'b1;
          state_d     = S_EMIT;
        end else begin
          cmd_o.next_p = 1'b1;
          state_d      = S_SEL;
        end
      end
      S_EMIT: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.emit_grant = 1'b1;
          if (sts_i.all_granted) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.next_p = 1'b1;
            state_d      = S_SEL;
          end
        end
      end
      S_FAIL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fail = 1'b1;
          state_d         = S_IDLE;
        end
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/bsc_dp.sv -----
// ----------------------------------------------------------------------------
// bsc_dp
// Datapath: need/held memory, available and work vectors, finished flags,
// pointers, configuration registers and the output register.
// ----------------------------------------------------------------------------
module bsc_dp import bsc_pkg::*; #(
  parameter int unsigned PROCESSES   = DEF_PROCESSES,
  parameter int unsigned RESOURCES   = DEF_RESOURCES,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bsc_req_if.sink               req,
  bsc_rsp_if.source             rsp,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  localparam int unsigned Depth = PROCESSES * RESOURCES;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PidxW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int unsigned PcntW = $clog2(PROCESSES + 1);
  localparam int unsigned RidxW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int unsigned RcntW = $clog2(RESOURCES + 1);
  localparam int unsigned WorkW = VALUE_WIDTH + 4;

  // Configuration registers
  logic [PC_W-1:0] pcount_q;
  logic [RC_W-1:0] rcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= PCOUNT_RST;
      rcount_q <= RCOUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PROCESS_COUNT:  pcount_q <= cfg_data_i[PC_W-1:0];
        REG_RESOURCE_COUNT: rcount_q <= cfg_data_i[RC_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate counts into the supported range
  logic [PcntW-1:0] np;
  logic [RcntW-1:0] nr;

  always_comb begin
    if (pcount_q == '0) begin
      np = PcntW'(1);
    end else if (32'(pcount_q) > PROCESSES) begin
      np = PcntW'(PROCESSES);
    end else begin
      np = PcntW'(pcount_q);
    end
    if (rcount_q == '0) begin
      nr = RcntW'(1);
    end else if (32'(rcount_q) > RESOURCES) begin
      nr = RcntW'(RESOURCES);
    end else begin
      nr = RcntW'(rcount_q);
    end
  end

  // Input decode
  logic                   accept;
  logic                   load_proc;
  logic                   load_avail;
  logic [AddrW-1:0]       wr_addr;
  logic [VALUE_WIDTH-1:0] mx_val;
  logic [VALUE_WIDTH-1:0] hd_val;
  logic [VALUE_WIDTH-1:0] need_val;

  assign req.ready  = cmd_i.take;
  assign accept     = req.valid & req.ready;
  assign load_proc  = accept && (req.func == FUNC_LOAD_PROC)
                      && (32'(req.process_index) < PROCESSES)
                      && (32'(req.resource_index) < RESOURCES);
  assign load_avail = accept && (req.func == FUNC_LOAD_AVAIL)
                      && (32'(req.resource_index) < RESOURCES);
  assign wr_addr    = AddrW'(32'(req.process_index) * RESOURCES + 32'(req.resource_index));
  assign mx_val     = VALUE_WIDTH'(req.max_value);
  assign hd_val     = VALUE_WIDTH'(req.held_value);
  assign need_val   = (mx_val > hd_val) ? (mx_val - hd_val) : '0;

  // Need/held memory: one write port for loads, one registered read port
  logic [2*VALUE_WIDTH-1:0] mem_q [Depth];
  logic [2*VALUE_WIDTH-1:0] rd_data_q;
  logic [AddrW-1:0]         rd_addr;

  logic [PcntW-1:0] p_q;
  logic [PidxW-1:0] p_idx;
  logic [RidxW-1:0] r_q;

  assign p_idx   = p_q[PidxW-1:0];
  assign rd_addr = AddrW'(32'(p_idx) * RESOURCES + 32'(r_q));

  always_ff @(posedge clk_i) begin
    if (load_proc) begin
      mem_q[wr_addr] <= {need_val, hd_val};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Available vector
  logic [VALUE_WIDTH-1:0] avail_q [RESOURCES];

  always_ff @(posedge clk_i) begin
    if (load_avail) begin
      avail_q[RidxW'(req.resource_index)] <= VALUE_WIDTH'(req.avail_value);
    end
  end

  // Compare one resource and form its tentative work value
  logic [VALUE_WIDTH-1:0] rd_need;
  logic [VALUE_WIDTH-1:0] rd_held;
  logic [WorkW-1:0]       work_cur;
  logic [WorkW:0]         sum;
  logic [WorkW-1:0]       sum_sat;
  logic                   fit_now;

  logic [WorkW-1:0]     work_q [RESOURCES];
  logic [WorkW-1:0]     temp_q [RESOURCES];
  logic                 fits_q;
  logic                 progress_q;
  logic [PROCESSES-1:0] finished_q;
  logic [PcntW-1:0]     granted_q;

  assign rd_need  = rd_data_q[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign rd_held  = rd_data_q[VALUE_WIDTH-1:0];
  assign work_cur = work_q[r_q];
  assign fit_now  = WorkW'(rd_need) <= work_cur;
  assign sum      = (WorkW+1)'(work_cur) + (WorkW+1)'(rd_held);
  assign sum_sat  = sum[WorkW] ? '1 : sum[WorkW-1:0];

  // Tentative work values
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      temp_q[r_q] <= sum_sat;
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q        <= '0;
      r_q        <= '0;
      fits_q     <= 1'b0;
      progress_q <= 1'b0;
      finished_q <= '0;
      granted_q  <= '0;
      for (int i = 0; i < RESOURCES; i++) begin
        work_q[i] <= '0;
      end
    end else begin
      if (cmd_i.init) begin
        p_q        <= '0;
        progress_q <= 1'b0;
        finished_q <= '0;
        granted_q  <= '0;
        for (int i = 0; i < RESOURCES; i++) begin
          work_q[i] <= WorkW'(avail_q[i]);
        end
      end
      if (cmd_i.new_pass) begin
        p_q        <= '0;
        progress_q <= 1'b0;
      end
      if (cmd_i.next_p) begin
        p_q <= p_q + PcntW'(1);
      end
      if (cmd_i.start_proc) begin
        r_q    <= '0;
        fits_q <= 1'b1;
      end
      if (cmd_i.eval) begin
        fits_q <= fits_q & fit_now;
      end
      if (cmd_i.next_r) begin
        r_q <= r_q + RidxW'(1);
      end
      // commit the granted process's held counts
      if (cmd_i.grant) begin
        for (int i = 0; i < RESOURCES; i++) begin
          if (i < int'(nr)) begin
            work_q[i] <= temp_q[i];
          end
        end
        finished_q[p_idx] <= 1'b1;
        granted_q         <= granted_q + PcntW'(1);
        progress_q        <= 1'b1;
      end
    end
  end

  // Output register
  logic            out_valid_q;
  logic [GP_W-1:0] gp_q;
  logic            safe_q;
  logic            last_q;
  logic            out_free;
  logic            all_granted;

  assign out_free    = !out_valid_q || rsp.ready;
  assign all_granted = (granted_q == np);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_grant || cmd_i.emit_fail) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_grant) begin
      gp_q   <= GP_W'(p_idx);
      safe_q <= all_granted;
      last_q <= all_granted;
    end else if (cmd_i.emit_fail) begin
      gp_q   <= '0;
      safe_q <= 1'b0;
      last_q <= 1'b1;
    end
  end

  assign rsp.valid           = out_valid_q;
  assign rsp.granted_process = gp_q;
  assign rsp.safe            = safe_q;
  assign rsp.last            = last_q;

  // Status to the sequencer
  assign sts_o.run_req     = req.valid && (req.func == FUNC_RUN);
  assign sts_o.p_end       = (p_q == np);
  assign sts_o.p_done      = finished_q[p_idx];
  assign sts_o.r_last      = ((RcntW'(r_q) + RcntW'(1)) == nr);
  assign sts_o.fits        = fits_q;
  assign sts_o.progress    = progress_q;
  assign sts_o.all_granted = all_granted;
  assign sts_o.out_free    = out_free;

`ifndef SYNTHESIS
  // A beat is loaded only when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_grant || cmd_i.emit_fail) |-> (!out_valid_q || rsp.ready))
    else $error("beat loaded into a full output register");

  // Finished flags and grant count move together
  a_count_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(finished_q) == int'(granted_q))
    else $error("grant count disagrees with finished flags");

  // A process is granted at most once per run
  a_grant_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant |-> !finished_q[p_idx])
    else $error("finished process granted again");

  // Only a final beat may report safe
  a_safe_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && safe_q) |-> last_q)
    else $error("safe flag on a non-final beat");
`endif

endmodule

// ----- sv/bankers_safety_check.sv -----
// ----------------------------------------------------------------------------
// bankers_safety_check
// Banker's algorithm safety check: loads need/held and available entries,
// then on a run emits the safe sequence or an unsafe final beat.
//
//   Channel  Dir  Handshake        Payload
//   req      in   valid/ready      func, process_index, resource_index,
//                                  max_value, held_value, avail_value
//   rsp      out  valid/ready      granted_process, safe, last
//   cfg      in   cfg_we_i only    cfg_index_i, cfg_data_i
//
// Load beats are accepted back to back while no run is in progress.
// A run opens with an init step; each pass visits every process and, for an
// unfinished one, does a read/compare pair per resource on the single read
// port of the need/held memory, then decides; a grant adds an emit step.
// Passes not finishing safe end with a check; unsafe runs add a fail step.
// req.ready is low from the run beat until its final beat sits in the output
// register; a stalled rsp holds the sequencer in its emit or fail step.
// No clearing pass after reset; stores hold garbage until loaded.
// ----------------------------------------------------------------------------
module bankers_safety_check import bsc_pkg::*; #(
  parameter int unsigned PROCESSES   = DEF_PROCESSES,
  parameter int unsigned RESOURCES   = DEF_RESOURCES,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bsc_req_if.sink               req,
  bsc_rsp_if.source             rsp
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  bsc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Stores, vectors and output register
  bsc_dp #(
    .PROCESSES   (PROCESSES),
    .RESOURCES   (RESOURCES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req         (req),
    .rsp         (rsp),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- tb/bankers_safety_check_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safety_check_test
// Self-checking bench for the banker's algorithm safety checker. Load and
// run beats go in over the request channel. A scoreboard keeps its own copy
// of the need/held/available tables and of both count registers, works out
// the grant sequence of every run, and checks each response beat in order.
// A short directed opening comes first. Random phases follow, each after a
// count setting is written, most with random idling on both channels, and
// one long response stall that backs the block up.
// ----------------------------------------------------------------------------
module bankers_safety_check_test;
  import bsc_pkg::*;

  localparam int unsigned WORK_W          = DEF_VALUE_WIDTH + 4;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned PHASE_BEATS     = 8;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [PIDX_IN_W-1:0] process_index;
    logic [RIDX_IN_W-1:0] resource_index;
    logic [VAL_IN_W-1:0]  max_value;
    logic [VAL_IN_W-1:0]  held_value;
    logic [VAL_IN_W-1:0]  avail_value;
  } request_t;

  typedef struct packed {
    logic [GP_W-1:0] granted_process;
    logic            safe;
    logic            last;
  } grant_beat_t;

  // Scoreboard: mirrors the tables and predicts the grant sequence of a run
  class safety_scoreboard;
    logic [VAL_IN_W-1:0] need_tbl [DEF_PROCESSES][DEF_RESOURCES];
    logic [VAL_IN_W-1:0] held_tbl [DEF_PROCESSES][DEF_RESOURCES];
    logic [VAL_IN_W-1:0] avail_tbl [DEF_RESOURCES];
    logic [WORK_W-1:0]   work_vec [DEF_RESOURCES];
    logic [DEF_PROCESSES-1:0] done_mask;
    int unsigned         grant_total;
    logic [PC_W-1:0]     pcount;
    logic [RC_W-1:0]     rcount;
    grant_beat_t         expected_beats [$];
    int unsigned errors, beats_seen, loads, runs, safe_runs, unsafe_runs, settings;

    function new();
      pcount = PCOUNT_RST;
      rcount = RCOUNT_RST;
      done_mask = '0;
      grant_total = 0;
      for (int p = 0; p < DEF_PROCESSES; p++) begin
        for (int r = 0; r < DEF_RESOURCES; r++) begin
          need_tbl[p][r] = '0;
          held_tbl[p][r] = '0;
        end
      end
      for (int r = 0; r < DEF_RESOURCES; r++) begin
        avail_tbl[r] = '0;
        work_vec[r] = '0;
      end
      errors = 0;
      beats_seen = 0;
      loads = 0;
      runs = 0;
      safe_runs = 0;
      unsafe_runs = 0;
      settings = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_PROCESS_COUNT) begin
        pcount = data[PC_W-1:0];
        settings++;
      end else begin
        rcount = data[RC_W-1:0];
      end
    endfunction

    // Out-of-range counts saturate into the legal range when used
    function int unsigned active_processes();
      if (pcount == 0) return 1;
      if (pcount > DEF_PROCESSES) return DEF_PROCESSES;
      return pcount;
    endfunction

    function int unsigned active_resources();
      if (rcount == 0) return 1;
      if (rcount > DEF_RESOURCES) return DEF_RESOURCES;
      return rcount;
    endfunction

    function void predict_sequence();
      int unsigned np;
      int unsigned nr;
      logic [WORK_W:0] sum;
      bit fits;
      bit progress;
      grant_beat_t beat;
      np = active_processes();
      nr = active_resources();
      done_mask = '0;
      grant_total = 0;
      runs++;
      for (int r = 0; r < DEF_RESOURCES; r++) work_vec[r] = WORK_W'(avail_tbl[r]);
      while (grant_total < np) begin
        progress = 1'b0;
        // one pass in index order over the unfinished processes
        for (int p = 0; p < np; p++) begin
          if (!done_mask[p]) begin
            fits = 1'b1;
            for (int r = 0; r < nr; r++) begin
              if (WORK_W'(need_tbl[p][r]) > work_vec[r]) fits = 1'b0;
            end
            if (fits) begin
              // release the held units, saturating each work entry
              for (int r = 0; r < nr; r++) begin
                sum = {1'b0, work_vec[r]} + (WORK_W + 1)'(held_tbl[p][r]);
                work_vec[r] = sum[WORK_W] ? '1 : sum[WORK_W-1:0];
              end
              done_mask[p] = 1'b1;
              grant_total++;
              progress = 1'b1;
              beat.granted_process = GP_W'(p);
              beat.safe = (grant_total == np);
              beat.last = (grant_total == np);
              expected_beats.push_back(beat);
            end
          end
        end
        if (!progress) begin
          beat.granted_process = '0;
          beat.safe = 1'b0;
          beat.last = 1'b1;
          expected_beats.push_back(beat);
          unsafe_runs++;
          break;
        end
      end
      if (grant_total == np) safe_runs++;
    endfunction

    function void note_request(request_t it);
      case (it.func)
        FUNC_LOAD_PROC: begin
          held_tbl[it.process_index][it.resource_index] = it.held_value;
          need_tbl[it.process_index][it.resource_index] =
            (it.max_value > it.held_value) ? it.max_value - it.held_value : '0;
          loads++;
        end
        FUNC_LOAD_AVAIL: begin
          avail_tbl[it.resource_index] = it.avail_value;
          loads++;
        end
        FUNC_RUN: predict_sequence();
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_beat(logic [GP_W-1:0] gp, logic safe_bit, logic last_bit);
      grant_beat_t want;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat process %0d safe %0b last %0b",
                                  gp, safe_bit, last_bit));
        return;
      end
      want = expected_beats.pop_front();
      if (gp !== want.granted_process)
        report_mismatch($sformatf("granted_process %0d, expected %0d",
                                  gp, want.granted_process));
      if (safe_bit !== want.safe)
        report_mismatch($sformatf("safe %0b, expected %0b", safe_bit, want.safe));
      if (last_bit !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", last_bit, want.last));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bsc_req_if req_ch ();
  bsc_rsp_if rsp_ch ();

  bankers_safety_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  safety_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_request;
  int unsigned counted_beats;
  bit          entry_loaded [DEF_PROCESSES][DEF_RESOURCES];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[bankers_safety_check] ERROR");
    $finish;
  end

  function automatic logic [VAL_IN_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return VAL_IN_W'($urandom_range(12));
    if (sel < 65) return '0;
    if (sel < 75) return '1;
    return VAL_IN_W'($urandom);
  endfunction

  function automatic request_t make_request(logic [FUNC_W-1:0] func,
                                            logic [PIDX_IN_W-1:0] p,
                                            logic [RIDX_IN_W-1:0] r,
                                            logic [VAL_IN_W-1:0] mx,
                                            logic [VAL_IN_W-1:0] hd,
                                            logic [VAL_IN_W-1:0] av);
    request_t it;
    it.func = func;
    it.process_index = p;
    it.resource_index = r;
    it.max_value = mx;
    it.held_value = hd;
    it.avail_value = av;
    return it;
  endfunction

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Offer one beat, idling first at random; valid stays up after acceptance
  task automatic send_request(request_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid          <= 1'b1;
    req_ch.func           <= it.func;
    req_ch.process_index  <= it.process_index;
    req_ch.resource_index <= it.resource_index;
    req_ch.max_value      <= it.max_value;
    req_ch.held_value     <= it.held_value;
    req_ch.avail_value    <= it.avail_value;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.note_request(it);
    if (it.func == FUNC_LOAD_PROC) entry_loaded[it.process_index][it.resource_index] = 1'b1;
    if (it.func != FUNC_UNUSED) counted_beats++;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] pc, logic [CFG_DATA_W-1:0] rc);
    write_register(REG_PROCESS_COUNT, pc);
    write_register(REG_RESOURCE_COUNT, rc);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, wait for every predicted beat, then let the block settle
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Fill any entry the coming run will read, then start the run
  task automatic send_run();
    for (int p = 0; p < sb.active_processes(); p++) begin
      for (int r = 0; r < sb.active_resources(); r++) begin
        if (!entry_loaded[p][r])
          send_request(make_request(FUNC_LOAD_PROC, PIDX_IN_W'(p), RIDX_IN_W'(r),
                                    pick_value(), pick_value(), VAL_IN_W'($urandom)));
      end
    end
    send_request(make_request(FUNC_RUN, PIDX_IN_W'($urandom), RIDX_IN_W'($urandom),
                              VAL_IN_W'($urandom), VAL_IN_W'($urandom),
                              VAL_IN_W'($urandom)));
  endtask

  task automatic directed_sequence();
    // available vector, all entries, so no run ever reads an unloaded one
    send_request(make_request(FUNC_LOAD_AVAIL, 3'd0, 2'd0, 16'h0, 16'h0, 16'd3));
    send_request(make_request(FUNC_LOAD_AVAIL, 3'd0, 2'd1, 16'h0, 16'h0, 16'hFFFF));
    send_request(make_request(FUNC_LOAD_AVAIL, 3'd0, 2'd2, 16'h0, 16'h0, 16'h5555));
    send_request(make_request(FUNC_LOAD_AVAIL, 3'd0, 2'd3, 16'h0, 16'h0, 16'hAAAA));
    // held above max clamps need to zero; full-scale claims
    send_request(make_request(FUNC_LOAD_PROC, 3'd0, 2'd0, 16'h0000, 16'hFFFF, 16'h0));
    send_request(make_request(FUNC_LOAD_PROC, 3'd0, 2'd1, 16'hFFFF, 16'hFFFF, 16'h0));
    send_request(make_request(FUNC_LOAD_PROC, 3'd1, 2'd0, 16'd5, 16'd1, 16'h0));
    send_request(make_request(FUNC_LOAD_PROC, 3'd1, 2'd1, 16'hFFFF, 16'h0000, 16'h0));
    send_run();
    // unused function code must change nothing
    send_request(make_request(FUNC_UNUSED, '1, '1, '1, '1, '1));
    // nothing fits: single unsafe beat
    send_request(make_request(FUNC_LOAD_AVAIL, 3'd0, 2'd0, 16'h0, 16'h0, 16'd0));
    send_request(make_request(FUNC_LOAD_PROC, 3'd0, 2'd0, 16'd1, 16'd0, 16'h0));
    send_request(make_request(FUNC_LOAD_PROC, 3'd1, 2'd0, 16'd1, 16'd0, 16'h0));
    send_run();
    // process 0 only fits after process 1 releases: second pass
    send_request(make_request(FUNC_LOAD_AVAIL, 3'd0, 2'd0, 16'h0, 16'h0, 16'd1));
    send_request(make_request(FUNC_LOAD_PROC, 3'd0, 2'd0, 16'd2, 16'd0, 16'h0));
    send_request(make_request(FUNC_LOAD_PROC, 3'd1, 2'd0, 16'd0, 16'd5, 16'h0));
    send_run();
  endtask

  // Mostly loads aimed at the active table with a run now and then
  task automatic random_phase(bit with_pressure);
    int unsigned start_count;
    int unsigned sel;
    int unsigned np;
    int unsigned nr;
    logic [PIDX_IN_W-1:0] p;
    logic [RIDX_IN_W-1:0] r;
    start_count = counted_beats;
    np = sb.active_processes();
    nr = sb.active_resources();
    while (counted_beats - start_count < PHASE_BEATS) begin
      sel = $urandom_range(99);
      p = ($urandom_range(99) < 80) ? PIDX_IN_W'($urandom_range(np - 1)) : PIDX_IN_W'($urandom);
      r = ($urandom_range(99) < 80) ? RIDX_IN_W'($urandom_range(nr - 1)) : RIDX_IN_W'($urandom);
      // open a pressured phase with a run so the long stall always happens
      if (sel < 16 || with_pressure) begin
        if (with_pressure) hold_off_request = 1'b1;
        with_pressure = 1'b0;
        send_run();
      end else if (sel < 21) begin
        send_request(make_request(FUNC_UNUSED, p, r, VAL_IN_W'($urandom),
                                  VAL_IN_W'($urandom), VAL_IN_W'($urandom)));
      end else if (sel < 80) begin
        send_request(make_request(FUNC_LOAD_PROC, p, r, pick_value(), pick_value(),
                                  VAL_IN_W'($urandom)));
      end else begin
        send_request(make_request(FUNC_LOAD_AVAIL, p, r, VAL_IN_W'($urandom),
                                  VAL_IN_W'($urandom),
                                  VAL_IN_W'($urandom_range(99) < 70 ? $urandom_range(24)
                                                                    : $urandom)));
      end
    end
    send_run();
  endtask

  // Response side: check accepted beats, stall at random, hold off on request
  initial begin : beat_sink
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_beat(rsp_ch.granted_process, rsp_ch.safe, rsp_ch.last);
      if (hold_off_request) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    sb = new();
    hold_off_request = 1'b0;
    counted_beats = 0;
    set_idle(24, 54);
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_index_i           <= '0;
    cfg_data_i            <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.func           <= '0;
    req_ch.process_index  <= '0;
    req_ch.resource_index <= '0;
    req_ch.max_value      <= '0;
    req_ch.held_value     <= '0;
    req_ch.avail_value    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_config(4'd2, 4'd2);
    directed_sequence();
    drain_results();

    // Sweep count settings, out-of-range values included
    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 3) set_idle(24, 54);
      else if (phase < 6) set_idle(54, 24);
      else set_idle(0, 0);
      case (phase)
        0: apply_config(4'd8, 4'd4);
        1: apply_config(4'd15, 4'd7);
        2: apply_config(4'd1, 4'd1);
        3: apply_config(4'd0, 4'd8);
        4: apply_config(4'd5, 4'd3);
        5: apply_config(4'd3, 4'd2);
        6: apply_config(4'd8, 4'd4);
        default: apply_config(4'd6, 4'd4);
      endcase
      random_phase(phase == 0);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d loads and %0d runs (%0d safe, %0d unsafe) over %0d settings",
             sb.loads, sb.runs, sb.safe_runs, sb.unsafe_runs, sb.settings);
    $display("checked %0d result beats, %0d mismatches", sb.beats_seen, sb.errors);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("[bankers_safety_check] OK");
    end else begin
      $display("[bankers_safety_check] ERROR");
    end
    $finish;
  end

endmodule
